// ===== hdl/gmrf_pkg.sv =====
package gmrf_pkg;

  localparam int PIN_COUNT_DEF    = 40;
  localparam int SIGNAL_COUNT_DEF = 256;
  localparam int DATA_W           = 32;
  localparam int OFF_W            = 12;
  localparam int REG_COUNT        = 6;

  localparam logic [OFF_W-1:0] PIN_BASE    = 12'h088;
  localparam logic [OFF_W-1:0] INSEL_BASE  = 12'h130;
  localparam logic [OFF_W-1:0] OUTSEL_BASE = 12'h530;

  localparam logic [OFF_W-1:0] OFF_OUT      = 12'h004;
  localparam logic [OFF_W-1:0] OFF_OUT_SET  = 12'h008;
  localparam logic [OFF_W-1:0] OFF_OUT_CLR  = 12'h00C;
  localparam logic [OFF_W-1:0] OFF_OUTH     = 12'h010;
  localparam logic [OFF_W-1:0] OFF_OUTH_SET = 12'h014;
  localparam logic [OFF_W-1:0] OFF_OUTH_CLR = 12'h018;
  localparam logic [OFF_W-1:0] OFF_EN       = 12'h020;
  localparam logic [OFF_W-1:0] OFF_EN_SET   = 12'h024;
  localparam logic [OFF_W-1:0] OFF_EN_CLR   = 12'h028;
  localparam logic [OFF_W-1:0] OFF_ENH      = 12'h02C;
  localparam logic [OFF_W-1:0] OFF_ENH_SET  = 12'h030;
  localparam logic [OFF_W-1:0] OFF_ENH_CLR  = 12'h034;
  localparam logic [OFF_W-1:0] OFF_ST       = 12'h044;
  localparam logic [OFF_W-1:0] OFF_ST_SET   = 12'h048;
  localparam logic [OFF_W-1:0] OFF_ST_CLR   = 12'h04C;
  localparam logic [OFF_W-1:0] OFF_STH      = 12'h050;

  typedef logic [2:0] reg_sel_t;
  typedef logic [1:0] reg_op_t;

  localparam reg_sel_t REG_OUT  = 3'd0;
  localparam reg_sel_t REG_OUTH = 3'd1;
  localparam reg_sel_t REG_EN   = 3'd2;
  localparam reg_sel_t REG_ENH  = 3'd3;
  localparam reg_sel_t REG_ST   = 3'd4;
  localparam reg_sel_t REG_STH  = 3'd5;

  localparam reg_op_t OP_WRITE = 2'd0;
  localparam reg_op_t OP_SET   = 2'd1;
  localparam reg_op_t OP_CLR   = 2'd2;

  typedef struct packed {
    logic     reg_hit;
    reg_sel_t reg_sel;
    reg_op_t  reg_op;
    logic     arr_hit;
  } dec_t;

endpackage

// ===== hdl/gmrf_decode.sv =====
module gmrf_decode #(
  parameter int PIN_COUNT    = gmrf_pkg::PIN_COUNT_DEF,
  parameter int SIGNAL_COUNT = gmrf_pkg::SIGNAL_COUNT_DEF,
  parameter int AW           = 9
) (
  input  logic [gmrf_pkg::OFF_W-1:0] offset,
  output gmrf_pkg::dec_t             dec,
  output logic [AW-1:0]              mem_addr
);

  localparam int PIN_END    = 32'(gmrf_pkg::PIN_BASE) + 4 * PIN_COUNT;
  localparam int INSEL_END  = 32'(gmrf_pkg::INSEL_BASE) + 4 * SIGNAL_COUNT;
  localparam int OUTSEL_END = 32'(gmrf_pkg::OUTSEL_BASE) + 4 * PIN_COUNT;
  localparam int INSEL_IDX  = PIN_COUNT;
  localparam int OUTSEL_IDX = PIN_COUNT + SIGNAL_COUNT;

  logic [12:0] off_ext;
  logic [gmrf_pkg::OFF_W-1:0] diff;
  logic arr_hit;

  assign off_ext = {1'b0, offset};

  always_comb begin
    dec.arr_hit = arr_hit;
    dec.reg_hit = 1'b1;
    dec.reg_sel = gmrf_pkg::REG_OUT;
    dec.reg_op  = gmrf_pkg::OP_WRITE;
    case (offset)
      gmrf_pkg::OFF_OUT:      begin dec.reg_sel = gmrf_pkg::REG_OUT;  end
      gmrf_pkg::OFF_OUT_SET:  begin dec.reg_sel = gmrf_pkg::REG_OUT;  dec.reg_op = gmrf_pkg::OP_SET; end
      gmrf_pkg::OFF_OUT_CLR:  begin dec.reg_sel = gmrf_pkg::REG_OUT;  dec.reg_op = gmrf_pkg::OP_CLR; end
      gmrf_pkg::OFF_OUTH:     begin dec.reg_sel = gmrf_pkg::REG_OUTH; end
      gmrf_pkg::OFF_OUTH_SET: begin dec.reg_sel = gmrf_pkg::REG_OUTH; dec.reg_op = gmrf_pkg::OP_SET; end
      gmrf_pkg::OFF_OUTH_CLR: begin dec.reg_sel = gmrf_pkg::REG_OUTH; dec.reg_op = gmrf_pkg::OP_CLR; end
      gmrf_pkg::OFF_EN:       begin dec.reg_sel = gmrf_pkg::REG_EN;   end
      gmrf_pkg::OFF_EN_SET:   begin dec.reg_sel = gmrf_pkg::REG_EN;   dec.reg_op = gmrf_pkg::OP_SET; end
      gmrf_pkg::OFF_EN_CLR:   begin dec.reg_sel = gmrf_pkg::REG_EN;   dec.reg_op = gmrf_pkg::OP_CLR; end
      gmrf_pkg::OFF_ENH:      begin dec.reg_sel = gmrf_pkg::REG_ENH;  end
      gmrf_pkg::OFF_ENH_SET:  begin dec.reg_sel = gmrf_pkg::REG_ENH;  dec.reg_op = gmrf_pkg::OP_SET; end
      gmrf_pkg::OFF_ENH_CLR:  begin dec.reg_sel = gmrf_pkg::REG_ENH;  dec.reg_op = gmrf_pkg::OP_CLR; end
      gmrf_pkg::OFF_ST:       begin dec.reg_sel = gmrf_pkg::REG_ST;   end
      gmrf_pkg::OFF_ST_SET:   begin dec.reg_sel = gmrf_pkg::REG_ST;   dec.reg_op = gmrf_pkg::OP_SET; end
      gmrf_pkg::OFF_ST_CLR:   begin dec.reg_sel = gmrf_pkg::REG_ST;   dec.reg_op = gmrf_pkg::OP_CLR; end
      gmrf_pkg::OFF_STH:      begin dec.reg_sel = gmrf_pkg::REG_STH;  end
      default:                begin dec.reg_hit = 1'b0; end
    endcase
  end

  always_comb begin
    arr_hit  = 1'b1;
    diff     = offset - gmrf_pkg::PIN_BASE;
    mem_addr = AW'(diff[gmrf_pkg::OFF_W-1:2]);
    if (offset >= gmrf_pkg::PIN_BASE && off_ext < 13'(PIN_END)) begin
      diff     = offset - gmrf_pkg::PIN_BASE;
      mem_addr = AW'(diff[gmrf_pkg::OFF_W-1:2]);
    end else if (offset >= gmrf_pkg::INSEL_BASE && off_ext < 13'(INSEL_END)) begin
      diff     = offset - gmrf_pkg::INSEL_BASE;
      mem_addr = AW'(diff[gmrf_pkg::OFF_W-1:2]) + AW'(INSEL_IDX);
    end else if (offset >= gmrf_pkg::OUTSEL_BASE && off_ext < 13'(OUTSEL_END)) begin
      diff     = offset - gmrf_pkg::OUTSEL_BASE;
      mem_addr = AW'(diff[gmrf_pkg::OFF_W-1:2]) + AW'(OUTSEL_IDX);
    end else begin
      arr_hit = 1'b0;
    end
  end

endmodule

// ===== hdl/gmrf_ram.sv =====
module gmrf_ram #(
  parameter int DEPTH = 336,
  parameter int AW    = 9
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         we,
  input  logic [AW-1:0]                addr,
  input  logic [gmrf_pkg::DATA_W-1:0]  wdata,
  output logic [gmrf_pkg::DATA_W-1:0]  rdata
);

  logic [gmrf_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en && !we) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hdl/gmrf_regs.sv =====
module gmrf_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  gmrf_pkg::dec_t              dec,
  input  logic [gmrf_pkg::DATA_W-1:0] wdata,
  output logic [gmrf_pkg::DATA_W-1:0] rdata
);

  logic [gmrf_pkg::DATA_W-1:0] regs [gmrf_pkg::REG_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gmrf_pkg::REG_COUNT; i++) begin
        regs[i] <= '0;
      end
    end else if (wr_en && dec.reg_hit) begin
      case (dec.reg_op)
        gmrf_pkg::OP_WRITE: regs[dec.reg_sel] <= wdata;
        gmrf_pkg::OP_SET:   regs[dec.reg_sel] <= regs[dec.reg_sel] | wdata;
        gmrf_pkg::OP_CLR:   regs[dec.reg_sel] <= regs[dec.reg_sel] & ~wdata;
        default:            regs[dec.reg_sel] <= regs[dec.reg_sel];
      endcase
    end
  end

  assign rdata = (dec.reg_hit && dec.reg_op == gmrf_pkg::OP_WRITE) ? regs[dec.reg_sel] : '0;

endmodule

// ===== hdl/gpio_matrix_register_file.sv =====
// GPIO matrix register file.
// Input stream s_axis: one bus access per transfer; tuser is the access kind
// (0 read, 1 write), tdata carries the byte offset and the write data.
// Output stream m_axis: exactly one transfer per access, read data for a
// read and zero for a write, in access order.
// Output, enable and interrupt status words live in flip-flops with direct,
// set and clear addresses (high status word: direct only). Pin config, input
// select and output select words share one single-port, registered-read memory.
// Pipeline: an access passes the read stage (p_valid) and then the output
// register (o_valid), which drives m_axis_tvalid.
// Throughput: one access per cycle, set by the single memory port (one read
// or one write per cycle), unless m_axis stalls or the reset sweep runs.
// Reset: control state clears at once; the memory is then swept to zero,
// one word per cycle, all 2*PIN_COUNT+SIGNAL_COUNT words (336 by default),
// with s_axis_tready low during the sweep.
// Stall: while m_axis_tready is low, one more access is taken and held in
// the read stage; further accesses wait.
module gpio_matrix_register_file #(
  parameter int PIN_COUNT    = gmrf_pkg::PIN_COUNT_DEF,
  parameter int SIGNAL_COUNT = gmrf_pkg::SIGNAL_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // offset[11:0], write_value[43:12], zero pad
  input  logic        s_axis_tuser,  // kind[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // read_data[31:0]
);

  localparam int MEM_DEPTH = 2 * PIN_COUNT + SIGNAL_COUNT;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  logic [gmrf_pkg::OFF_W-1:0]  offset;
  logic [gmrf_pkg::DATA_W-1:0] write_value;
  logic                        kind;
  logic                        accept;
  gmrf_pkg::dec_t              dec;
  logic [MEM_AW-1:0]           dec_addr;
  logic [gmrf_pkg::DATA_W-1:0] reg_rdata;
  logic [gmrf_pkg::DATA_W-1:0] mem_rdata;
  logic                        mem_en;
  logic                        mem_we;
  logic [MEM_AW-1:0]           mem_addr;
  logic [gmrf_pkg::DATA_W-1:0] mem_wdata;

  logic                        clearing;
  logic [MEM_AW-1:0]           clr_addr;
  logic                        p_valid;
  logic                        p_arr;
  logic [gmrf_pkg::DATA_W-1:0] p_sdata;
  logic                        p_move;
  logic                        o_valid;
  logic [gmrf_pkg::DATA_W-1:0] o_data;

  assign offset      = s_axis_tdata[11:0];
  assign write_value = s_axis_tdata[43:12];
  assign kind        = s_axis_tuser;

  assign p_move        = p_valid && (!o_valid || m_axis_tready);
  assign s_axis_tready = !clearing && (!p_valid || p_move);
  assign accept        = s_axis_tvalid && s_axis_tready;

  gmrf_decode #(
    .PIN_COUNT    (PIN_COUNT),
    .SIGNAL_COUNT (SIGNAL_COUNT),
    .AW           (MEM_AW)
  ) u_decode (
    .offset   (offset),
    .dec      (dec),
    .mem_addr (dec_addr)
  );

  gmrf_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .wr_en (accept && kind),
    .dec   (dec),
    .wdata (write_value),
    .rdata (reg_rdata)
  );

  assign mem_en    = clearing || (accept && dec.arr_hit);
  assign mem_we    = clearing || kind;
  assign mem_addr  = clearing ? clr_addr : dec_addr;
  assign mem_wdata = clearing ? '0 : write_value;

  gmrf_ram #(
    .DEPTH (MEM_DEPTH),
    .AW    (MEM_AW)
  ) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + MEM_AW'(1);
      if (clr_addr == MEM_AW'(MEM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (p_move) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_arr   <= !kind && dec.arr_hit;
      p_sdata <= kind ? '0 : reg_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (p_move) begin
      o_valid <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      o_data <= p_arr ? mem_rdata : p_sdata;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = o_data;

endmodule
